// ----- hw/rtl/ftce_pkg.sv -----
// Package for the five-register toy CPU execute unit.
// Holds widths, instruction codes, the decoded micro-op and the result record.
// Depends on nothing; every other file of the block but ftce_ram imports it.
`default_nettype none

package ftce_pkg;

    // Datapath and storage sizes.
    localparam int DATA_WIDTH = 32;
    localparam int IMM_WIDTH  = 32;
    localparam int MEM_WORDS  = 64;
    localparam int ADDR_W     = $clog2(MEM_WORDS);
    localparam int NUM_REGS   = 5;
    localparam int REG_IDX_W  = 3;
    localparam int TGT_W      = 10;
    localparam int ACT_W      = 3;
    localparam int FORM_W     = 3;

    // Depth of the queue between decode and execute, and of the result queue.
    localparam int FQ_DEPTH   = 2;
    localparam int FQ_PTR_W   = 1;
    localparam int FQ_CNT_W   = 2;
    localparam int RQ_DEPTH   = 2;
    localparam int RQ_PTR_W   = 1;
    localparam int RQ_CNT_W   = 2;

    // Instruction actions.
    typedef enum logic [ACT_W-1:0] {
        ACT_MOV = 3'd0,
        ACT_ADD = 3'd1,
        ACT_SUB = 3'd2,
        ACT_PRN = 3'd3,
        ACT_JMP = 3'd4,
        ACT_JPN = 3'd5,
        ACT_HLT = 3'd6
    } t_action;

    // Operand forms of data instructions.
    localparam logic [FORM_W-1:0] FORM_REG_IMM = 3'd0;
    localparam logic [FORM_W-1:0] FORM_REG_REG = 3'd1;
    localparam logic [FORM_W-1:0] FORM_REG_MEM = 3'd2;
    localparam logic [FORM_W-1:0] FORM_MEM_REG = 3'd3;
    localparam logic [FORM_W-1:0] FORM_MEM_IMM = 3'd4;

    // Forms of jump instructions.
    localparam logic [FORM_W-1:0] FORM_JMP_ALWAYS = 3'd0;
    localparam logic [FORM_W-1:0] FORM_JMP_REG    = 3'd1;

    // Operand source of a register write.
    typedef enum logic [1:0] {
        SRC_IMM,
        SRC_REG,
        SRC_MEM
    } t_src;

    // ALU operation.
    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_ADD,
        ALU_SUB
    } t_alu;

    // Jump condition.
    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_ZERO,
        JMP_LEZ
    } t_jump;

    // Decoded micro-op handed from the front end to the execute stage.
    typedef struct packed {
        logic                  reg_we;
        logic [REG_IDX_W-1:0]  reg_a;
        logic [REG_IDX_W-1:0]  reg_b;
        t_src                  src;
        t_alu                  alu;
        logic                  mem_we;
        logic                  mem_from_reg;
        t_jump                 jump;
        logic                  halt;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] imm;
        logic [TGT_W-1:0]      target;
    } t_op;

    // One result record.
    typedef struct packed {
        logic [NUM_REGS-1:0][DATA_WIDTH-1:0] regs;
        logic [DATA_WIDTH-1:0]               mem_value;
        logic                                jump_taken;
        logic [TGT_W-1:0]                    jump_target;
        logic                                halted;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/ftce_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the data memory of the execute stage.
`default_nettype none

module ftce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read in the same cycle as a write to the same word returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/ftce_front.sv -----
// Front end: accepts instructions, classifies them into micro-ops and queues them.
// Depends on ftce_pkg.
`default_nettype none

module ftce_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic [ftce_pkg::ACT_W-1:0]     i_action,
    input  wire logic [ftce_pkg::FORM_W-1:0]    i_form,
    input  wire logic [ftce_pkg::REG_IDX_W-1:0] i_reg_a,
    input  wire logic [ftce_pkg::REG_IDX_W-1:0] i_reg_b,
    input  wire logic [ftce_pkg::ADDR_W-1:0]    i_mem_addr,
    input  wire logic [ftce_pkg::IMM_WIDTH-1:0] i_immediate,
    input  wire logic [ftce_pkg::TGT_W-1:0]     i_target_line,
    output logic                                o_head_vld,
    output ftce_pkg::t_op                       o_head,
    input  wire logic                           i_head_pop
);

    import ftce_pkg::*;

    t_op                 n_op;
    logic                va;
    logic                push_ok;
    t_op                 r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wptr;
    logic [FQ_PTR_W-1:0] r_rptr;
    logic [FQ_CNT_W-1:0] r_cnt;

    // Classify the instruction; meaningless forms become a no-op.
    always_comb begin
        va               = (i_reg_a < REG_IDX_W'(NUM_REGS));
        n_op             = '0;
        n_op.src         = SRC_IMM;
        n_op.alu         = ALU_PASS;
        n_op.jump        = JMP_NONE;
        n_op.reg_a       = i_reg_a;
        n_op.reg_b       = i_reg_b;
        n_op.addr        = i_mem_addr;
        n_op.imm         = DATA_WIDTH'($signed(i_immediate));
        n_op.target      = i_target_line;
        unique case (t_action'(i_action))
            ACT_MOV: begin
                case (i_form)
                    FORM_REG_IMM: begin
                        n_op.reg_we = va;
                        n_op.src    = SRC_IMM;
                    end
                    FORM_REG_REG: begin
                        n_op.reg_we = va;
                        n_op.src    = SRC_REG;
                    end
                    FORM_REG_MEM: begin
                        n_op.reg_we = va;
                        n_op.src    = SRC_MEM;
                    end
                    FORM_MEM_REG: begin
                        n_op.mem_we       = 1'b1;
                        n_op.mem_from_reg = 1'b1;
                    end
                    FORM_MEM_IMM: begin
                        n_op.mem_we = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_ADD, ACT_SUB: begin
                n_op.alu = (t_action'(i_action) == ACT_ADD) ? ALU_ADD : ALU_SUB;
                case (i_form)
                    FORM_REG_IMM: begin
                        n_op.reg_we = va;
                        n_op.src    = SRC_IMM;
                    end
                    FORM_REG_REG: begin
                        n_op.reg_we = va;
                        n_op.src    = SRC_REG;
                    end
                    FORM_REG_MEM: begin
                        n_op.reg_we = va;
                        n_op.src    = SRC_MEM;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_JMP, ACT_JPN: begin
                if (i_form == FORM_JMP_ALWAYS) begin
                    n_op.jump = JMP_ALWAYS;
                end else if (i_form == FORM_JMP_REG && va) begin
                    n_op.jump = (t_action'(i_action) == ACT_JMP) ? JMP_ZERO : JMP_LEZ;
                end
            end
            ACT_HLT: begin
                n_op.halt = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_full     = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign push_ok    = i_push && !o_full;
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_q[r_rptr];

    // Queue payload storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wptr] <= n_op;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_head_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push_ok && !i_head_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push_ok && i_head_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ftce_back.sv -----
// Execute stage: register file, data memory and ALU; produces one result per micro-op.
// Depends on ftce_pkg and ftce_ram.
`default_nettype none

module ftce_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_head_vld,
    input  wire ftce_pkg::t_op i_head,
    output logic          o_head_pop,
    output logic          o_res_vld,
    output ftce_pkg::t_result o_res,
    input  wire logic     i_res_full
);

    import ftce_pkg::*;

    logic                  r_s2_vld;
    t_op                   r_s2_op;
    logic [DATA_WIDTH-1:0] r_regs [NUM_REGS];
    logic [MEM_WORDS-1:0]  r_mem_vld;
    logic                  r_byp;
    logic [DATA_WIDTH-1:0] r_byp_data;

    logic                  s2_fire;
    logic                  ram_we;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] a_val;
    logic [DATA_WIDTH-1:0] b_val;
    logic [DATA_WIDTH-1:0] mem_old;
    logic [DATA_WIDTH-1:0] operand;
    logic [DATA_WIDTH-1:0] alu_res;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] n_regs [NUM_REGS];
    logic                  taken;

    // The stage fires when its result can enter the result queue; a new
    // micro-op is loaded, and its memory word read, whenever the stage frees up.
    assign s2_fire    = r_s2_vld && !i_res_full;
    assign o_head_pop = i_head_vld && (!r_s2_vld || s2_fire);
    assign ram_we     = s2_fire && r_s2_op.mem_we;

    ftce_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_op.addr),
        .i_wdata (wdata),
        .i_re    (o_head_pop),
        .i_raddr (i_head.addr),
        .o_rdata (ram_rdata)
    );

    // Operand fetch, ALU and result assembly.
    always_comb begin
        a_val = (r_s2_op.reg_a < REG_IDX_W'(NUM_REGS)) ? r_regs[r_s2_op.reg_a] : '0;
        b_val = (r_s2_op.reg_b < REG_IDX_W'(NUM_REGS)) ? r_regs[r_s2_op.reg_b] : '0;

        // Words never written read as zero; a write at the load edge is bypassed.
        if (r_byp) begin
            mem_old = r_byp_data;
        end else if (r_mem_vld[r_s2_op.addr]) begin
            mem_old = ram_rdata;
        end else begin
            mem_old = '0;
        end

        case (r_s2_op.src)
            SRC_REG: operand = b_val;
            SRC_MEM: operand = mem_old;
            default: operand = r_s2_op.imm;
        endcase

        case (r_s2_op.alu)
            ALU_ADD: alu_res = a_val + operand;
            ALU_SUB: alu_res = a_val - operand;
            default: alu_res = operand;
        endcase

        wdata = r_s2_op.mem_from_reg ? a_val : r_s2_op.imm;

        for (int i = 0; i < NUM_REGS; i++) begin
            n_regs[i] = r_regs[i];
        end
        if (r_s2_op.reg_we) begin
            n_regs[r_s2_op.reg_a] = alu_res;
        end

        case (r_s2_op.jump)
            JMP_ALWAYS: taken = 1'b1;
            JMP_ZERO:   taken = (a_val == '0);
            JMP_LEZ:    taken = (a_val == '0) || a_val[DATA_WIDTH-1];
            default:    taken = 1'b0;
        endcase

        for (int i = 0; i < NUM_REGS; i++) begin
            o_res.regs[i] = n_regs[i];
        end
        o_res.mem_value   = r_s2_op.mem_we ? wdata : mem_old;
        o_res.jump_taken  = taken;
        o_res.jump_target = taken ? r_s2_op.target : '0;
        o_res.halted      = r_s2_op.halt;
    end

    assign o_res_vld = s2_fire;

    // Stage payload and memory-write bypass capture.
    always_ff @(posedge i_clk) begin
        if (o_head_pop) begin
            r_s2_op    <= i_head;
            r_byp      <= ram_we && (r_s2_op.addr == i_head.addr);
            r_byp_data <= wdata;
        end
    end

    // Stage valid, register file and memory valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_mem_vld <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (o_head_pop) begin
                r_s2_vld <= 1'b1;
            end else if (s2_fire) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_fire) begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    r_regs[i] <= n_regs[i];
                end
            end
            if (ram_we) begin
                r_mem_vld[r_s2_op.addr] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ftce_outq.sv -----
// Result queue: holds finished results until the consumer takes them.
// Depends on ftce_pkg.
`default_nettype none

module ftce_outq (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire ftce_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_empty,
    input  wire logic         i_rd,
    output ftce_pkg::t_result o_data
);

    import ftce_pkg::*;

    t_result             r_q [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wptr;
    logic [RQ_PTR_W-1:0] r_rptr;
    logic [RQ_CNT_W-1:0] r_cnt;
    logic                rd_ok;

    assign o_full  = (r_cnt == RQ_CNT_W'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign rd_ok   = i_rd && !o_empty;
    assign o_data  = r_q[r_rptr];

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_wr && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && rd_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/five_register_toy_cpu_execute.sv -----
// Execute unit of a toy five-register machine with a 64-word data memory.
// Path: front queue, execute stage register, result queue, then the output ports.
// Throughput: one instruction per cycle while the result queue has room; the single
// execute stage reads, computes and writes back with a bypass for memory words.
// Reset (synchronous, active low) empties both queues and zeroes the registers;
// memory words read as zero until written, with no clearing pass.
`default_nettype none

module five_register_toy_cpu_execute (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [ftce_pkg::ACT_W-1:0]     i_action,
    input  wire logic [ftce_pkg::FORM_W-1:0]    i_form,
    input  wire logic [ftce_pkg::REG_IDX_W-1:0] i_reg_a,
    input  wire logic [ftce_pkg::REG_IDX_W-1:0] i_reg_b,
    input  wire logic [ftce_pkg::ADDR_W-1:0]    i_mem_addr,
    input  wire logic signed [ftce_pkg::IMM_WIDTH-1:0] i_immediate,
    input  wire logic [ftce_pkg::TGT_W-1:0]     i_target_line,
    output logic                                empty,
    input  wire logic                           pop,
    output logic signed [ftce_pkg::DATA_WIDTH-1:0] o_reg_one,
    output logic signed [ftce_pkg::DATA_WIDTH-1:0] o_reg_two,
    output logic signed [ftce_pkg::DATA_WIDTH-1:0] o_reg_three,
    output logic signed [ftce_pkg::DATA_WIDTH-1:0] o_reg_four,
    output logic signed [ftce_pkg::DATA_WIDTH-1:0] o_reg_five,
    output logic [ftce_pkg::DATA_WIDTH-1:0]     o_mem_value,
    output logic                                o_jump_taken,
    output logic [ftce_pkg::TGT_W-1:0]          o_jump_target,
    output logic                                o_halted
);

    import ftce_pkg::*;

    logic    head_vld;
    t_op     head;
    logic    head_pop;
    logic    res_vld;
    t_result res;
    logic    res_full;
    t_result out_res;

    // Front end: transfer, decode and queue.
    ftce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_form        (i_form),
        .i_reg_a       (i_reg_a),
        .i_reg_b       (i_reg_b),
        .i_mem_addr    (i_mem_addr),
        .i_immediate   (i_immediate),
        .i_target_line (i_target_line),
        .o_head_vld    (head_vld),
        .o_head        (head),
        .i_head_pop    (head_pop)
    );

    // Back end: execute against the register file and memory.
    ftce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_head_pop (head_pop),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_full (res_full)
    );

    // Result queue toward the consumer.
    ftce_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_vld),
        .i_data  (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_rd    (pop),
        .o_data  (out_res)
    );

    // Unpack the oldest result onto the ports.
    assign o_reg_one     = $signed(out_res.regs[0]);
    assign o_reg_two     = $signed(out_res.regs[1]);
    assign o_reg_three   = $signed(out_res.regs[2]);
    assign o_reg_four    = $signed(out_res.regs[3]);
    assign o_reg_five    = $signed(out_res.regs[4]);
    assign o_mem_value   = out_res.mem_value;
    assign o_jump_taken  = out_res.jump_taken;
    assign o_jump_target = out_res.jump_target;
    assign o_halted      = out_res.halted;

endmodule

`default_nettype wire

// ----- test/five_register_toy_cpu_execute_test.sv -----
// Self-checking testbench for the five-register toy CPU execute unit.
// Drives decoded instructions through the push/full queue, predicts registers, memory and
// jumps in its own machine copy, and checks every popped result. Depends on ftce_pkg.
`timescale 1ns / 100ps

module five_register_toy_cpu_execute_test;
    import ftce_pkg::*;

    // Codes that the package does not name.
    localparam logic [ACT_W-1:0]     ACT_SPARE   = 3'd7;
    localparam logic [FORM_W-1:0]    FORM_UNUSED = 3'd5;
    localparam logic [FORM_W-1:0]    FORM_TOP    = 3'd7;
    localparam logic [FORM_W-1:0]    FORM_JMP_BAD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_R1  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_R2  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_R3  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_R4  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_R5  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BAD = 3'd7;
    localparam logic [DATA_WIDTH-1:0] IMM_MAX = 32'h7fff_ffff;
    localparam logic [DATA_WIDTH-1:0] IMM_MIN = 32'h8000_0000;
    localparam logic [DATA_WIDTH-1:0] IMM_ONE = 32'h0000_0001;
    localparam logic [DATA_WIDTH-1:0] IMM_ALL = 32'hffff_ffff;
    localparam logic [ADDR_W-1:0]     ADDR_TOP = 6'd63;
    localparam logic [TGT_W-1:0]      LINE_TOP = 10'd1023;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int SHOWN_MISMATCHES = 10;

    // One decoded instruction as the testbench sees it.
    typedef struct {
        logic [ACT_W-1:0]      action;
        logic [FORM_W-1:0]     form;
        logic [REG_IDX_W-1:0]  reg_a;
        logic [REG_IDX_W-1:0]  reg_b;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] imm;
        logic [TGT_W-1:0]      target;
    } t_instr_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  pop = 1'b0;
    logic [ACT_W-1:0]      i_action = '0;
    logic [FORM_W-1:0]     i_form = '0;
    logic [REG_IDX_W-1:0]  i_reg_a = '0;
    logic [REG_IDX_W-1:0]  i_reg_b = '0;
    logic [ADDR_W-1:0]     i_mem_addr = '0;
    logic [IMM_WIDTH-1:0]  i_immediate = '0;
    logic [TGT_W-1:0]      i_target_line = '0;
    wire logic             full;
    wire logic             empty;
    wire logic signed [DATA_WIDTH-1:0] o_reg_one;
    wire logic signed [DATA_WIDTH-1:0] o_reg_two;
    wire logic signed [DATA_WIDTH-1:0] o_reg_three;
    wire logic signed [DATA_WIDTH-1:0] o_reg_four;
    wire logic signed [DATA_WIDTH-1:0] o_reg_five;
    wire logic [DATA_WIDTH-1:0]        o_mem_value;
    wire logic             o_jump_taken;
    wire logic [TGT_W-1:0] o_jump_target;
    wire logic             o_halted;

    // Machine state as predicted, and the results still owed by the block.
    logic [DATA_WIDTH-1:0] machine_regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] machine_mem [MEM_WORDS];
    t_result               machine_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int checked_results = 0;
    int cycle_count = 0;

    five_register_toy_cpu_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_form        (i_form),
        .i_reg_a       (i_reg_a),
        .i_reg_b       (i_reg_b),
        .i_mem_addr    (i_mem_addr),
        .i_immediate   (i_immediate),
        .i_target_line (i_target_line),
        .empty         (empty),
        .pop           (pop),
        .o_reg_one     (o_reg_one),
        .o_reg_two     (o_reg_two),
        .o_reg_three   (o_reg_three),
        .o_reg_four    (o_reg_four),
        .o_reg_five    (o_reg_five),
        .o_mem_value   (o_mem_value),
        .o_jump_taken  (o_jump_taken),
        .o_jump_target (o_jump_target),
        .o_halted      (o_halted)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Registers outside R1..R5 read as zero and drop writes.
    function automatic logic [DATA_WIDTH-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
        return (idx < NUM_REGS) ? machine_regs[idx] : '0;
    endfunction

    function automatic void write_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [DATA_WIDTH-1:0] value);
        if (idx < NUM_REGS) begin
            machine_regs[idx] = value;
        end
    endfunction

    // Applies one instruction to the machine copy and returns the result it reports.
    function automatic t_result run_instruction(input t_instr_item ins);
        t_result               res;
        logic [DATA_WIDTH-1:0] operand;
        logic [DATA_WIDTH-1:0] current;
        logic [DATA_WIDTH-1:0] tested;
        logic                  have_operand;
        logic                  taken;
        logic                  halt;
        res = '0;
        operand = '0;
        have_operand = 1'b1;
        taken = 1'b0;
        halt = 1'b0;
        case (ins.action)
            ACT_MOV: begin
                case (ins.form)
                    FORM_REG_IMM: write_reg(ins.reg_a, ins.imm);
                    FORM_REG_REG: write_reg(ins.reg_a, read_reg(ins.reg_b));
                    FORM_REG_MEM: write_reg(ins.reg_a, machine_mem[ins.addr]);
                    FORM_MEM_REG: machine_mem[ins.addr] = read_reg(ins.reg_a);
                    FORM_MEM_IMM: machine_mem[ins.addr] = ins.imm;
                    default: ;
                endcase
            end
            ACT_ADD, ACT_SUB: begin
                case (ins.form)
                    FORM_REG_IMM: operand = ins.imm;
                    FORM_REG_REG: operand = read_reg(ins.reg_b);
                    FORM_REG_MEM: operand = machine_mem[ins.addr];
                    default: have_operand = 1'b0;
                endcase
                if (have_operand) begin
                    current = read_reg(ins.reg_a);
                    write_reg(ins.reg_a, (ins.action == ACT_ADD) ? current + operand
                                                                 : current - operand);
                end
            end
            ACT_JMP, ACT_JPN: begin
                if (ins.form == FORM_JMP_ALWAYS) begin
                    taken = 1'b1;
                end else if (ins.form == FORM_JMP_REG && ins.reg_a < NUM_REGS) begin
                    tested = machine_regs[ins.reg_a];
                    taken = (tested == '0) || (ins.action == ACT_JPN && tested[DATA_WIDTH-1]);
                end
            end
            ACT_HLT: halt = 1'b1;
            default: ;
        endcase
        for (int i = 0; i < NUM_REGS; i++) begin
            res.regs[i] = machine_regs[i];
        end
        res.mem_value = machine_mem[ins.addr];
        res.jump_taken = taken;
        res.jump_target = taken ? ins.target : '0;
        res.halted = halt;
        return res;
    endfunction

    // Offers one instruction and returns right after the edge of its transfer.
    task automatic send_instr(input t_instr_item ins);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_action <= ins.action;
        i_form <= ins.form;
        i_reg_a <= ins.reg_a;
        i_reg_b <= ins.reg_b;
        i_mem_addr <= ins.addr;
        i_immediate <= ins.imm;
        i_target_line <= ins.target;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        machine_results.push_back(run_instruction(ins));
    endtask

    task automatic send_op(input logic [ACT_W-1:0] action, input logic [FORM_W-1:0] form,
                           input logic [REG_IDX_W-1:0] reg_a,
                           input logic [REG_IDX_W-1:0] reg_b,
                           input logic [ADDR_W-1:0] addr, input logic [DATA_WIDTH-1:0] imm,
                           input logic [TGT_W-1:0] target);
        t_instr_item ins;
        ins.action = action;
        ins.form = form;
        ins.reg_a = reg_a;
        ins.reg_b = reg_b;
        ins.addr = addr;
        ins.imm = imm;
        ins.target = target;
        send_instr(ins);
    endtask

    // Moves in every form, with the immediate extremes and both ends of memory.
    task automatic test_data_moves();
        send_op(ACT_MOV, FORM_REG_IMM, REG_R1, REG_R1, '0, IMM_MAX, '0);
        send_op(ACT_MOV, FORM_REG_IMM, REG_R2, REG_R1, '0, IMM_MIN, LINE_TOP);
        send_op(ACT_MOV, FORM_REG_REG, REG_R3, REG_R1, ADDR_TOP, '0, '0);
        send_op(ACT_MOV, FORM_MEM_REG, REG_R2, REG_R5, ADDR_TOP, IMM_ALL, '0);
        send_op(ACT_MOV, FORM_MEM_IMM, REG_R5, REG_R5, '0, IMM_ALL, '0);
        send_op(ACT_MOV, FORM_REG_MEM, REG_R4, REG_R1, ADDR_TOP, '0, '0);
        send_op(ACT_MOV, FORM_REG_MEM, REG_R5, REG_R2, '0, '0, '0);
    endtask

    // Add and subtract with wrap-around, a register used on itself, and a memory operand.
    task automatic test_arithmetic();
        send_op(ACT_ADD, FORM_REG_IMM, REG_R1, REG_R2, '0, IMM_ONE, '0);
        send_op(ACT_SUB, FORM_REG_IMM, REG_R2, REG_R1, '0, IMM_ONE, '0);
        send_op(ACT_ADD, FORM_REG_REG, REG_R3, REG_R3, '0, '0, '0);
        send_op(ACT_SUB, FORM_REG_REG, REG_R4, REG_R4, '0, '0, '0);
        send_op(ACT_ADD, FORM_REG_MEM, REG_R5, REG_R1, '0, '0, '0);
    endtask

    // Unconditional jumps, and conditional ones on zero, positive and negative registers.
    task automatic test_jumps();
        send_op(ACT_JMP, FORM_JMP_ALWAYS, REG_R1, REG_R1, '0, '0, LINE_TOP);
        send_op(ACT_JMP, FORM_JMP_REG, REG_R4, REG_R1, '0, '0, 10'h155);
        send_op(ACT_JMP, FORM_JMP_REG, REG_R1, REG_R1, '0, '0, 10'h2aa);
        send_op(ACT_JPN, FORM_JMP_REG, REG_R5, REG_R1, '0, '0, 10'h3f0);
        send_op(ACT_JPN, FORM_JMP_REG, REG_R2, REG_R1, '0, '0, 10'h00f);
        send_op(ACT_JPN, FORM_JMP_ALWAYS, REG_R3, REG_R1, '0, '0, '0);
    endtask

    // Registers out of range, forms without meaning, the spare action, PRN and HLT.
    task automatic test_special_cases();
        send_op(ACT_MOV, FORM_REG_IMM, REG_BAD, REG_R1, '0, IMM_MAX, '0);
        send_op(ACT_JMP, FORM_JMP_REG, REG_BAD, REG_R1, '0, '0, LINE_TOP);
        send_op(ACT_ADD, FORM_MEM_REG, REG_R1, REG_R2, ADDR_TOP, IMM_ALL, '0);
        send_op(ACT_MOV, FORM_TOP, REG_R1, REG_BAD, ADDR_TOP, IMM_ALL, LINE_TOP);
        send_op(ACT_JPN, FORM_JMP_BAD, REG_R4, REG_R1, '0, '0, LINE_TOP);
        send_op(ACT_SPARE, FORM_UNUSED, REG_R2, REG_R3, ADDR_TOP, IMM_ALL, LINE_TOP);
        send_op(ACT_PRN, FORM_REG_IMM, REG_R1, REG_R1, ADDR_TOP, '0, '0);
        send_op(ACT_HLT, FORM_REG_IMM, REG_R1, REG_R1, '0, '0, LINE_TOP);
    endtask

    // Mostly well-formed instructions on a few hot words, with some raw noise.
    function automatic t_instr_item random_instr();
        t_instr_item ins;
        int          pick;
        pick = $urandom_range(99);
        ins.reg_a = REG_IDX_W'($urandom_range(NUM_REGS - 1));
        ins.reg_b = REG_IDX_W'($urandom_range(NUM_REGS - 1));
        ins.addr = ADDR_W'(($urandom_range(3) == 0) ? $urandom_range(MEM_WORDS - 1)
                                                    : $urandom_range(7));
        ins.target = TGT_W'($urandom_range(LINE_TOP));
        case ($urandom_range(7))
            0: ins.imm = '0;
            1: ins.imm = IMM_ONE;
            2: ins.imm = IMM_ALL;
            3: ins.imm = ($urandom_range(1) != 0) ? IMM_MAX : IMM_MIN;
            4, 5: ins.imm = $urandom_range(32) - 16;
            default: ins.imm = $urandom;
        endcase
        if (pick < 8) begin
            ins.action = ACT_W'($urandom_range(ACT_SPARE));
            ins.form = FORM_W'($urandom_range(FORM_TOP));
            ins.reg_a = REG_IDX_W'($urandom_range(REG_BAD));
            ins.reg_b = REG_IDX_W'($urandom_range(REG_BAD));
        end else begin
            ins.action = ($urandom_range(39) == 0) ? ACT_HLT
                                                   : ACT_W'($urandom_range(ACT_JPN));
            case (ins.action)
                ACT_MOV: ins.form = FORM_W'($urandom_range(FORM_MEM_IMM));
                ACT_ADD, ACT_SUB: ins.form = FORM_W'($urandom_range(FORM_REG_MEM));
                ACT_JMP, ACT_JPN: ins.form = FORM_W'($urandom_range(FORM_JMP_REG));
                default: ins.form = FORM_W'($urandom_range(FORM_TOP));
            endcase
        end
        return ins;
    endfunction

    // A random program under one pattern of sender gaps and receiver stalls.
    task automatic test_random_program(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE) begin
            send_instr(random_instr());
        end
    endtask

    // Receiver side: pop at random, held low during reset.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic flag_mismatch(input string what, input logic [DATA_WIDTH-1:0] want,
                                 input logic [DATA_WIDTH-1:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("Mismatch on %s in result %0d: expected %h, got %h.",
                     what, checked_results, want, got);
        end
    endtask

    // Each result transfer is checked field by field against the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got.regs[0] = o_reg_one;
            got.regs[1] = o_reg_two;
            got.regs[2] = o_reg_three;
            got.regs[3] = o_reg_four;
            got.regs[4] = o_reg_five;
            got.mem_value = o_mem_value;
            got.jump_taken = o_jump_taken;
            got.jump_target = o_jump_target;
            got.halted = o_halted;
            if (machine_results.size() == 0) begin
                flag_mismatch("unexpected result, mem_value", '0, got.mem_value);
            end else begin
                want = machine_results.pop_front();
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (got.regs[i] !== want.regs[i]) begin
                        flag_mismatch($sformatf("register R%0d", i + 1),
                                      want.regs[i], got.regs[i]);
                    end
                end
                if (got.mem_value !== want.mem_value) begin
                    flag_mismatch("mem_value", want.mem_value, got.mem_value);
                end
                if (got.jump_taken !== want.jump_taken) begin
                    flag_mismatch("jump_taken", DATA_WIDTH'(want.jump_taken),
                                  DATA_WIDTH'(got.jump_taken));
                end
                if (got.jump_target !== want.jump_target) begin
                    flag_mismatch("jump_target", DATA_WIDTH'(want.jump_target),
                                  DATA_WIDTH'(got.jump_target));
                end
                if (got.halted !== want.halted) begin
                    flag_mismatch("halted", DATA_WIDTH'(want.halted),
                                  DATA_WIDTH'(got.halted));
                end
            end
            checked_results++;
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++) begin
            machine_regs[i] = '0;
        end
        for (int i = 0; i < MEM_WORDS; i++) begin
            machine_mem[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_data_moves();
        test_arithmetic();
        test_jumps();
        test_special_cases();
        test_random_program(0, 0);
        test_random_program(73, 0);
        test_random_program(0, 73);
        test_random_program(31, 31);
        push <= 1'b0;

        // Drain the owed results, then give the pipeline time to show any extra one.
        while (machine_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
